// ===== sv/reseq_pkg.sv =====
// ----------------------------------------------------------------------------
// reseq_pkg
// Shared types and constants for the rotary encoder step qualifier.
// ----------------------------------------------------------------------------
package reseq_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_DEBOUNCE = 1'b0;
  localparam cfg_idx_t CFG_REV_HOLD = 1'b1;

  localparam cfg_data_t DEBOUNCE_RST = 16'd2;
  localparam cfg_data_t REV_HOLD_RST = 16'd100;

  typedef enum logic [1:0] {
    OC_STEP   = 2'd0,
    OC_BOUNCE = 2'd1,
    OC_A_HIGH = 2'd2,
    OC_HELD   = 2'd3
  } outcome_t;

  typedef struct packed {
    logic     step_upd;
    logic     dir_upd;
    logic     cw;
    logic     ccw;
    outcome_t outcome;
  } decision_t;

endpackage

// ===== sv/reseq_in_if.sv =====
// ----------------------------------------------------------------------------
// reseq_in_if
// Pin-change word channel: valid/ready plus event payload.
// ----------------------------------------------------------------------------
interface reseq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        encoder_sel;
  logic        a_level;
  logic        b_level;

  modport source (output valid, now_ms, encoder_sel, a_level, b_level, input ready);
  modport sink   (input valid, now_ms, encoder_sel, a_level, b_level, output ready);
endinterface

// ===== sv/reseq_out_if.sv =====
// ----------------------------------------------------------------------------
// reseq_out_if
// Result word channel: valid/ready plus step report payload.
// ----------------------------------------------------------------------------
interface reseq_out_if;
  logic       valid;
  logic       ready;
  logic       cw_step;
  logic       ccw_step;
  logic       encoder_id;
  logic [1:0] outcome;

  modport source (output valid, cw_step, ccw_step, encoder_id, outcome, input ready);
  modport sink   (input valid, cw_step, ccw_step, encoder_id, outcome, output ready);
endinterface

// ===== sv/rotary_encoder_step_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_step_qualifier_unit
// Debounces channel-A pin changes of quadrature encoders and reports steps.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per channel-A pin change (time, encoder, A and B level).
//   out_ch : one result word per change on an existing encoder: step flags,
//            encoder id and outcome code. Changes on a nonexistent encoder
//            are consumed with no result.
//   cfg_*  : write port, index 0 debounce time, index 1 reversal hold time,
//            in ms. Write only while the block is idle.
//   Flow: an accepted input word passes through the input register, then
//   the result register, where out_ch.valid rises. Throughput: one word
//   per cycle while out_ch.ready does not stall the result register; the
//   per-encoder state is read and updated in the cycle a word leaves the
//   input register, so back-to-back words on one encoder see fresh state.
//   Reset: debounce 2 ms, hold 100 ms, all encoder times and directions
//   cleared (clockwise), both registers empty.
//   Stall: with out_ch.ready low the result register holds its word; one
//   more word waits in the input register, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module rotary_encoder_step_qualifier_unit #(
  parameter int ENCODER_COUNT = 2,
  parameter int TIME_BITS     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  reseq_in_if.sink             in_ch,
  reseq_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  reseq_pkg::cfg_idx_t  cfg_idx,
  input  reseq_pkg::cfg_data_t cfg_wdata
);
  import reseq_pkg::*;

  localparam int IDX_W = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;

  cfg_data_t debounce_r;
  cfg_data_t rev_hold_r;

  logic        s1_v_r;
  logic [31:0] s1_now_r;
  logic        s1_sel_r;
  logic        s1_a_r;
  logic        s1_b_r;

  logic     out_v_r;
  logic     cw_r;
  logic     ccw_r;
  logic     id_r;
  outcome_t oc_r;

  logic                 s1_in_range;
  logic                 s1_adv;
  logic                 s1_emit;
  logic [IDX_W-1:0]     s1_idx;
  logic [TIME_BITS-1:0] s1_now;
  logic [TIME_BITS-1:0] last_change;
  logic [TIME_BITS-1:0] last_step;
  logic                 last_dir;
  decision_t            dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      rev_hold_r <= REV_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_REV_HOLD: rev_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_in_range = int'(s1_sel_r) < ENCODER_COUNT;
  assign s1_adv      = s1_v_r && (!s1_in_range || !out_v_r || out_ch.ready);
  assign s1_emit     = s1_adv && s1_in_range;
  assign s1_idx      = s1_in_range ? IDX_W'(s1_sel_r) : '0;
  assign s1_now      = TIME_BITS'(s1_now_r);
  assign in_ch.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_now_r <= in_ch.now_ms;
      s1_sel_r <= in_ch.encoder_sel;
      s1_a_r   <= in_ch.a_level;
      s1_b_r   <= in_ch.b_level;
    end
  end

  reseq_state #(
    .ENCODER_COUNT (ENCODER_COUNT),
    .TIME_BITS     (TIME_BITS)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (s1_emit),
    .idx         (s1_idx),
    .now         (s1_now),
    .dir         (s1_b_r),
    .dec         (dec),
    .last_change (last_change),
    .last_step   (last_step),
    .last_dir    (last_dir)
  );

  reseq_decide #(
    .TIME_BITS (TIME_BITS)
  ) u_decide (
    .now         (s1_now),
    .a_level     (s1_a_r),
    .dir         (s1_b_r),
    .last_change (last_change),
    .last_step   (last_step),
    .last_dir    (last_dir),
    .debounce    (debounce_r),
    .rev_hold    (rev_hold_r),
    .dec         (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_emit) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      cw_r  <= dec.cw;
      ccw_r <= dec.ccw;
      id_r  <= s1_sel_r;
      oc_r  <= dec.outcome;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.cw_step    = cw_r;
  assign out_ch.ccw_step   = ccw_r;
  assign out_ch.encoder_id = id_r;
  assign out_ch.outcome    = oc_r;

`ifndef SYNTHESIS
  a_step_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (((oc_r == OC_STEP) == (cw_r | ccw_r)) && !(cw_r && ccw_r)))
    else $error("step flags disagree with outcome");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |=> out_v_r)
    else $error("qualified word lost before result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !s1_v_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== sv/reseq_decide.sv =====
// ----------------------------------------------------------------------------
// reseq_decide
// Classifies one pin change against the selected encoder's saved state.
// ----------------------------------------------------------------------------
module reseq_decide #(
  parameter int TIME_BITS = 32
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic                 a_level,
  input  logic                 dir,
  input  logic [TIME_BITS-1:0] last_change,
  input  logic [TIME_BITS-1:0] last_step,
  input  logic                 last_dir,
  input  reseq_pkg::cfg_data_t debounce,
  input  reseq_pkg::cfg_data_t rev_hold,
  output reseq_pkg::decision_t dec
);
  import reseq_pkg::*;

  logic [TIME_BITS-1:0] diff_chg;
  logic [TIME_BITS-1:0] diff_step;
  logic                 bounce;
  logic                 hold_ok;
  logic                 step;

  assign diff_chg  = now - last_change;
  assign diff_step = now - last_step;
  assign bounce    = diff_chg <= TIME_BITS'(debounce);
  assign hold_ok   = diff_step > TIME_BITS'(rev_hold);

  always_comb begin
    dec          = '0;
    dec.outcome  = OC_STEP;
    if (bounce) begin
      dec.outcome = OC_BOUNCE;
    end else if (a_level) begin
      dec.outcome = OC_A_HIGH;
    end else if (last_dir == dir) begin
      dec.step_upd = 1'b1;
    end else if (hold_ok) begin
      dec.dir_upd = 1'b1;
    end else begin
      dec.outcome = OC_HELD;
    end
    step    = (dec.outcome == OC_STEP);
    dec.cw  = step & ~dir;
    dec.ccw = step & dir;
  end

endmodule

// ===== sv/reseq_state.sv =====
// ----------------------------------------------------------------------------
// reseq_state
// Per-encoder change time, step time and direction, with update port.
// ----------------------------------------------------------------------------
module reseq_state #(
  parameter int  ENCODER_COUNT = 2,
  parameter int  TIME_BITS     = 32,
  localparam int IDX_W         = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     idx,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 dir,
  input  reseq_pkg::decision_t dec,
  output logic [TIME_BITS-1:0] last_change,
  output logic [TIME_BITS-1:0] last_step,
  output logic                 last_dir
);
  import reseq_pkg::*;

  logic [TIME_BITS-1:0] chg_r  [ENCODER_COUNT];
  logic [TIME_BITS-1:0] step_r [ENCODER_COUNT];
  logic                 dir_r  [ENCODER_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENCODER_COUNT; i++) begin
        chg_r[i]  <= '0;
        step_r[i] <= '0;
        dir_r[i]  <= 1'b0;
      end
    end else if (wr_en) begin
      chg_r[idx] <= now;
      if (dec.step_upd) begin
        step_r[idx] <= now;
      end
      if (dec.dir_upd) begin
        dir_r[idx] <= dir;
      end
    end
  end

  assign last_change = chg_r[idx];
  assign last_step   = step_r[idx];
  assign last_dir    = dir_r[idx];

endmodule
